### src/tcs_pkg.sv
// Shared types, constants and helper functions for the triangle coverage scanner.
package tcs_pkg;

    // Coordinate format and pixel grid
    localparam int COORD_FRAC_BITS  = 4;
    localparam int PIXEL_COORD_BITS = 10;
    localparam int VERT_W           = 16;
    localparam int SIZE_W           = 11;
    localparam int SCREEN_CAP       = 1 << PIXEL_COORD_BITS;

    // Configuration port
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 3;
    localparam int ADDR_W   = IDX_W + 2;
    localparam int DATA_W   = 32;

    localparam logic [IDX_W-1:0] REG_VERT0_X   = 3'd0;
    localparam logic [IDX_W-1:0] REG_VERT0_Y   = 3'd1;
    localparam logic [IDX_W-1:0] REG_VERT1_X   = 3'd2;
    localparam logic [IDX_W-1:0] REG_VERT1_Y   = 3'd3;
    localparam logic [IDX_W-1:0] REG_VERT2_X   = 3'd4;
    localparam logic [IDX_W-1:0] REG_VERT2_Y   = 3'd5;
    localparam logic [IDX_W-1:0] REG_SCREEN_W  = 3'd6;
    localparam logic [IDX_W-1:0] REG_SCREEN_H  = 3'd7;

    localparam logic [SIZE_W-1:0] SCREEN_W_RST = 11'd800;
    localparam logic [SIZE_W-1:0] SCREEN_H_RST = 11'd600;

    // Arithmetic widths for the edge functions
    localparam int POS_W  = PIXEL_COORD_BITS + COORD_FRAC_BITS;
    localparam int DIFF_W = ((POS_W > VERT_W) ? POS_W : VERT_W) + 2;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int EDGE_W = PROD_W + 1;
    localparam int BOX_W  = VERT_W + 1;

    // Winding codes
    localparam logic [1:0] WIND_NONE = 2'd0;
    localparam logic [1:0] WIND_CCW  = 2'd1;
    localparam logic [1:0] WIND_CW   = 2'd2;

    // Queue between sequencer and coverage pipeline
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Triangle and screen setup as held in the register file
    typedef struct packed {
        logic signed [VERT_W-1:0] x0;
        logic signed [VERT_W-1:0] y0;
        logic signed [VERT_W-1:0] x1;
        logic signed [VERT_W-1:0] y1;
        logic signed [VERT_W-1:0] x2;
        logic signed [VERT_W-1:0] y2;
        logic [SIZE_W-1:0]        width;
        logic [SIZE_W-1:0]        height;
    } t_tri;

    // One pixel beat from the sequencer
    typedef struct packed {
        logic                        start;
        logic                        pixel_valid;
        logic [PIXEL_COORD_BITS-1:0] x;
        logic [PIXEL_COORD_BITS-1:0] y;
        logic                        last;
    } t_pix;

    // Largest pixel index for a screen size; 0 counts as 1, oversize is capped
    function automatic logic [PIXEL_COORD_BITS-1:0] size_max(input logic [SIZE_W-1:0] s);
        logic [PIXEL_COORD_BITS-1:0] r;
        if (s == '0) begin
            r = '0;
        end else if (32'(s) > 32'(SCREEN_CAP)) begin
            r = '1;
        end else begin
            r = PIXEL_COORD_BITS'(s - 1'b1);
        end
        return r;
    endfunction

    // Clamp a signed box limit into [0, lim]
    function automatic logic [PIXEL_COORD_BITS-1:0] clamp_coord(
        input logic signed [BOX_W-1:0]   v,
        input logic [PIXEL_COORD_BITS-1:0] lim
    );
        logic signed [BOX_W-1:0]     l;
        logic [PIXEL_COORD_BITS-1:0] r;
        l = BOX_W'(lim);
        if (v < 0) begin
            r = '0;
        end else if (v > l) begin
            r = lim;
        end else begin
            r = PIXEL_COORD_BITS'(v);
        end
        return r;
    endfunction

    // Floor of a fixed point coordinate, widened for the +/-1 margin
    function automatic logic signed [BOX_W-1:0] floor_box(input logic signed [VERT_W-1:0] v);
        logic signed [VERT_W-1:0] f;
        f = v >>> COORD_FRAC_BITS;
        return BOX_W'(f);
    endfunction

    function automatic logic signed [VERT_W-1:0] min3(
        input logic signed [VERT_W-1:0] a,
        input logic signed [VERT_W-1:0] b,
        input logic signed [VERT_W-1:0] c
    );
        logic signed [VERT_W-1:0] m;
        m = (a < b) ? a : b;
        return (c < m) ? c : m;
    endfunction

    function automatic logic signed [VERT_W-1:0] max3(
        input logic signed [VERT_W-1:0] a,
        input logic signed [VERT_W-1:0] b,
        input logic signed [VERT_W-1:0] c
    );
        logic signed [VERT_W-1:0] m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction

endpackage

### src/tcs_cfg.sv
// APB register file holding the triangle vertices and screen size.
module tcs_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcs_pkg::ADDR_W-1:0]  paddr,
    input  logic [tcs_pkg::DATA_W-1:0]  pwdata,
    output logic [tcs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output tcs_pkg::t_tri               o_tri
);

    tcs_pkg::t_tri                r_tri;
    logic                         wr_en;
    logic [tcs_pkg::IDX_W-1:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[tcs_pkg::ADDR_W-1:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri.x0     <= '0;
            r_tri.y0     <= '0;
            r_tri.x1     <= '0;
            r_tri.y1     <= '0;
            r_tri.x2     <= '0;
            r_tri.y2     <= '0;
            r_tri.width  <= tcs_pkg::SCREEN_W_RST;
            r_tri.height <= tcs_pkg::SCREEN_H_RST;
        end else if (wr_en) begin
            unique case (idx)
                tcs_pkg::REG_VERT0_X:  r_tri.x0     <= pwdata[tcs_pkg::VERT_W-1:0];
                tcs_pkg::REG_VERT0_Y:  r_tri.y0     <= pwdata[tcs_pkg::VERT_W-1:0];
                tcs_pkg::REG_VERT1_X:  r_tri.x1     <= pwdata[tcs_pkg::VERT_W-1:0];
                tcs_pkg::REG_VERT1_Y:  r_tri.y1     <= pwdata[tcs_pkg::VERT_W-1:0];
                tcs_pkg::REG_VERT2_X:  r_tri.x2     <= pwdata[tcs_pkg::VERT_W-1:0];
                tcs_pkg::REG_VERT2_Y:  r_tri.y2     <= pwdata[tcs_pkg::VERT_W-1:0];
                tcs_pkg::REG_SCREEN_W: r_tri.width  <= pwdata[tcs_pkg::SIZE_W-1:0];
                tcs_pkg::REG_SCREEN_H: r_tri.height <= pwdata[tcs_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux, zero extended
    always_comb begin
        unique case (idx)
            tcs_pkg::REG_VERT0_X:  prdata = tcs_pkg::DATA_W'($unsigned(r_tri.x0));
            tcs_pkg::REG_VERT0_Y:  prdata = tcs_pkg::DATA_W'($unsigned(r_tri.y0));
            tcs_pkg::REG_VERT1_X:  prdata = tcs_pkg::DATA_W'($unsigned(r_tri.x1));
            tcs_pkg::REG_VERT1_Y:  prdata = tcs_pkg::DATA_W'($unsigned(r_tri.y1));
            tcs_pkg::REG_VERT2_X:  prdata = tcs_pkg::DATA_W'($unsigned(r_tri.x2));
            tcs_pkg::REG_VERT2_Y:  prdata = tcs_pkg::DATA_W'($unsigned(r_tri.y2));
            tcs_pkg::REG_SCREEN_W: prdata = tcs_pkg::DATA_W'(r_tri.width);
            tcs_pkg::REG_SCREEN_H: prdata = tcs_pkg::DATA_W'(r_tri.height);
            default:               prdata = '0;
        endcase
    end

    assign o_tri = r_tri;

endmodule

### src/tcs_front.sv
// Scan sequencer: takes tick beats, latches the bounding box, steps the pixel position.
module tcs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tcs_pkg::t_tri i_tri,
    input  logic          i_accept,
    input  logic          i_start_scan,
    output tcs_pkg::t_pix o_beat
);

    localparam int PW = tcs_pkg::PIXEL_COORD_BITS;

    logic          r_scanning;
    logic [PW-1:0] r_col;
    logic [PW-1:0] r_row;
    logic [PW-1:0] r_cend;
    logic [PW-1:0] r_rbeg;
    logic [PW-1:0] r_rend;

    logic [PW-1:0] w_max;
    logic [PW-1:0] h_max;
    logic [PW-1:0] box_c0;
    logic [PW-1:0] box_c1;
    logic [PW-1:0] box_r0;
    logic [PW-1:0] box_r1;
    logic [PW-1:0] cur_col;
    logic [PW-1:0] cur_row;
    logic [PW-1:0] cur_cend;
    logic [PW-1:0] cur_rbeg;
    logic [PW-1:0] cur_rend;
    logic          active;
    logic          last;

    // Bounding box of the configured triangle, one pixel of margin each side
    always_comb begin
        w_max  = tcs_pkg::size_max(i_tri.width);
        h_max  = tcs_pkg::size_max(i_tri.height);
        box_c0 = tcs_pkg::clamp_coord(
            tcs_pkg::floor_box(tcs_pkg::min3(i_tri.x0, i_tri.x1, i_tri.x2)) - 2'sd1, w_max);
        box_c1 = tcs_pkg::clamp_coord(
            tcs_pkg::floor_box(tcs_pkg::max3(i_tri.x0, i_tri.x1, i_tri.x2)) + 2'sd1, w_max);
        box_r0 = tcs_pkg::clamp_coord(
            tcs_pkg::floor_box(tcs_pkg::min3(i_tri.y0, i_tri.y1, i_tri.y2)) - 2'sd1, h_max);
        box_r1 = tcs_pkg::clamp_coord(
            tcs_pkg::floor_box(tcs_pkg::max3(i_tri.y0, i_tri.y1, i_tri.y2)) + 2'sd1, h_max);
    end

    // Position of this beat: a start restarts at the box corner
    always_comb begin
        cur_col  = i_start_scan ? box_c0 : r_col;
        cur_row  = i_start_scan ? box_r0 : r_row;
        cur_cend = i_start_scan ? box_c1 : r_cend;
        cur_rbeg = i_start_scan ? box_r0 : r_rbeg;
        cur_rend = i_start_scan ? box_r1 : r_rend;
        active   = i_start_scan | r_scanning;
        last     = (cur_col == cur_cend) && (cur_row == cur_rend);
    end

    // Beat to the queue; idle ticks carry all zeros
    always_comb begin
        o_beat.start       = i_start_scan;
        o_beat.pixel_valid = active;
        o_beat.x           = active ? cur_col : '0;
        o_beat.y           = active ? cur_row : '0;
        o_beat.last        = active & last;
    end

    // Scan state: y inner, x outer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_cend     <= '0;
            r_rbeg     <= '0;
            r_rend     <= '0;
        end else if (i_accept && active) begin
            r_cend <= cur_cend;
            r_rbeg <= cur_rbeg;
            r_rend <= cur_rend;
            priority if (last) begin
                r_scanning <= 1'b0;
                r_col      <= cur_col;
                r_row      <= cur_row;
            end else if (cur_row < cur_rend) begin
                r_scanning <= 1'b1;
                r_col      <= cur_col;
                r_row      <= cur_row + 1'b1;
            end else begin
                r_scanning <= 1'b1;
                r_col      <= cur_col + 1'b1;
                r_row      <= cur_rbeg;
            end
        end
    end

`ifndef SYNTHESIS
    a_col_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scanning |-> (r_col <= r_cend))
        else $error("scan column ran past the box");
    a_row_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scanning |-> (r_row >= r_rbeg && r_row <= r_rend))
        else $error("scan row left the box");
`endif

endmodule

### src/tcs_fifo.sv
// Short beat queue between the scan sequencer and the coverage pipeline.
module tcs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcs_pkg::t_pix i_beat,
    input  logic          i_pop,
    output tcs_pkg::t_pix o_beat,
    output logic          o_empty,
    output logic          o_full
);

    tcs_pkg::t_pix                   r_mem [tcs_pkg::FIFO_DEPTH];
    logic [tcs_pkg::FIFO_PTR_W-1:0]  r_wp;
    logic [tcs_pkg::FIFO_PTR_W-1:0]  r_rp;
    logic [tcs_pkg::FIFO_CNT_W-1:0]  r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == tcs_pkg::FIFO_CNT_W'(tcs_pkg::FIFO_DEPTH));
    assign o_beat  = r_mem[r_rp];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_beat;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tcs_pkg::FIFO_CNT_W'(tcs_pkg::FIFO_DEPTH))
        else $error("queue fill count above depth");
`endif

endmodule

### src/tcs_back.sv
// Coverage pipeline: edge functions, winding latch and the output register.
module tcs_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tcs_pkg::t_tri                          i_tri,
    input  tcs_pkg::t_pix                          i_beat,
    input  logic                                   i_beat_valid,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_pixel_valid,
    output logic [tcs_pkg::PIXEL_COORD_BITS-1:0]   o_pixel_x,
    output logic [tcs_pkg::PIXEL_COORD_BITS-1:0]   o_pixel_y,
    output logic                                   o_covered,
    output logic                                   o_scan_last
);

    localparam int DW = tcs_pkg::DIFF_W;
    localparam int PW = tcs_pkg::PROD_W;
    localparam int EW = tcs_pkg::EDGE_W;

    logic en;

    // Stage 1: coordinate differences
    logic                 r_v1;
    tcs_pkg::t_pix        r_b1;
    logic signed [DW-1:0] r_dx [3];
    logic signed [DW-1:0] r_dy [3];
    logic signed [DW-1:0] r_qx [3];
    logic signed [DW-1:0] r_qy [3];
    logic signed [DW-1:0] r_ax;
    logic signed [DW-1:0] r_ay;

    // Stage 2: products
    logic                 r_v2;
    tcs_pkg::t_pix        r_b2;
    logic signed [PW-1:0] r_p1 [3];
    logic signed [PW-1:0] r_p2 [3];
    logic signed [PW-1:0] r_ap1;
    logic signed [PW-1:0] r_ap2;

    // Stage 3: output register
    logic                 r_v3;
    tcs_pkg::t_pix        r_b3;
    logic                 r_cov;
    logic [1:0]           r_wind;

    logic signed [DW-1:0] vx [3];
    logic signed [DW-1:0] vy [3];
    logic signed [DW-1:0] px;
    logic signed [DW-1:0] py;
    logic signed [EW-1:0] e [3];
    logic signed [EW-1:0] area;
    logic [1:0]           area_wind;
    logic [1:0]           wind_eff;
    logic                 cov;

    // Whole pipeline moves unless a result sits stalled at the output
    assign en    = !(r_v3 && i_out_stall);
    assign o_pop = en && i_beat_valid;

    // Vertices and pixel center in a common signed width
    always_comb begin
        vx[0] = DW'(i_tri.x0);
        vy[0] = DW'(i_tri.y0);
        vx[1] = DW'(i_tri.x1);
        vy[1] = DW'(i_tri.y1);
        vx[2] = DW'(i_tri.x2);
        vy[2] = DW'(i_tri.y2);
        px    = $signed(DW'(i_beat.x) << tcs_pkg::COORD_FRAC_BITS);
        py    = $signed(DW'(i_beat.y) << tcs_pkg::COORD_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1 <= i_beat;
            for (int k = 0; k < 3; k++) begin
                r_dx[k] <= vx[(k + 1) % 3] - vx[k];
                r_dy[k] <= vy[(k + 1) % 3] - vy[k];
                r_qx[k] <= px - vx[k];
                r_qy[k] <= py - vy[k];
            end
            r_ax <= vx[2] - vx[0];
            r_ay <= vy[2] - vy[0];
        end
    end

    // Cross products of each edge and of the whole triangle
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b2 <= r_b1;
            for (int k = 0; k < 3; k++) begin
                r_p1[k] <= PW'(r_dx[k]) * PW'(r_qy[k]);
                r_p2[k] <= PW'(r_dy[k]) * PW'(r_qx[k]);
            end
            r_ap1 <= PW'(r_dx[0]) * PW'(r_ay);
            r_ap2 <= PW'(r_dy[0]) * PW'(r_ax);
        end
    end

    // Edge values, winding, coverage
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e[k] = EW'(r_p1[k]) - EW'(r_p2[k]);
        end
        area = EW'(r_ap1) - EW'(r_ap2);
        priority if (area > 0) begin
            area_wind = tcs_pkg::WIND_CCW;
        end else if (area < 0) begin
            area_wind = tcs_pkg::WIND_CW;
        end else begin
            area_wind = tcs_pkg::WIND_NONE;
        end
        wind_eff = r_b2.start ? area_wind : r_wind;
        unique case (wind_eff)
            tcs_pkg::WIND_CCW: cov = (e[0] >= 0) && (e[1] >= 0) && (e[2] >= 0);
            tcs_pkg::WIND_CW:  cov = (e[0] <= 0) && (e[1] <= 0) && (e[2] <= 0);
            default:           cov = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b3  <= r_b2;
            r_cov <= cov & r_b2.pixel_valid;
        end
    end

    // Stage valids and latched winding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_wind <= tcs_pkg::WIND_NONE;
        end else if (en) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v2 && r_b2.start) begin
                r_wind <= area_wind;
            end
        end
    end

    assign o_out_valid   = r_v3;
    assign o_pixel_valid = r_b3.pixel_valid;
    assign o_pixel_x     = r_b3.x;
    assign o_pixel_y     = r_b3.y;
    assign o_covered     = r_cov;
    assign o_scan_last   = r_b3.last;

`ifndef SYNTHESIS
    a_last_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_b3.last) |-> r_b3.pixel_valid)
        else $error("last flag on a beat that names no pixel");
    a_idle_uncovered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_b3.pixel_valid) |-> (!r_cov && r_b3.x == '0 && r_b3.y == '0))
        else $error("idle beat carries pixel data");
    a_start_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v2 && r_b2.start) |=> (r_wind == $past(area_wind)))
        else $error("winding not latched on scan start");
`endif

endmodule

### src/triangle_coverage_scanner_core.sv
// Top level of the triangle coverage scanner: register file, sequencer, queue, coverage pipeline.
//
//  channel | direction | handshake                      | payload
//  --------+-----------+--------------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall        | i_start_scan
//  out     | output    | o_out_valid / i_out_stall      | o_pixel_valid, o_pixel_x, o_pixel_y,
//          |           |                                | o_covered, o_scan_last
//  cfg     | input     | psel, penable, pwrite / pready | paddr, pwdata, prdata
//
// One beat in gives one beat out; one beat per clock sustained while neither the input nor the output stalls.
// From input accept a beat passes through the queue, then the difference, multiply and compare stages, to output valid.
// o_in_stall rises only when the four-entry beat queue is full; an output stall freezes
// the coverage pipeline while the sequencer keeps filling the queue.
// Reset (synchronous, active low) leaves no scan active and the registers at their defaults.
module triangle_coverage_scanner_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_start_scan,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_pixel_valid,
    output logic [tcs_pkg::PIXEL_COORD_BITS-1:0]  o_pixel_x,
    output logic [tcs_pkg::PIXEL_COORD_BITS-1:0]  o_pixel_y,
    output logic                                  o_covered,
    output logic                                  o_scan_last,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tcs_pkg::ADDR_W-1:0]            paddr,
    input  logic [tcs_pkg::DATA_W-1:0]            pwdata,
    output logic [tcs_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready
);

    tcs_pkg::t_tri tri_cfg;
    tcs_pkg::t_pix front_beat;
    tcs_pkg::t_pix queue_beat;
    logic          in_accept;
    logic          q_empty;
    logic          q_full;
    logic          q_pop;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid & ~q_full;

    // Configuration registers
    tcs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_tri   (tri_cfg)
    );

    // Scan sequencer
    tcs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tri        (tri_cfg),
        .i_accept     (in_accept),
        .i_start_scan (i_start_scan),
        .o_beat       (front_beat)
    );

    // Beat queue
    tcs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_beat  (front_beat),
        .i_pop   (q_pop),
        .o_beat  (queue_beat),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Coverage pipeline
    tcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tri         (tri_cfg),
        .i_beat        (queue_beat),
        .i_beat_valid  (~q_empty),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_valid (o_pixel_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_covered     (o_covered),
        .o_scan_last   (o_scan_last)
    );

endmodule

### tb/tb_triangle_coverage_scanner_core.sv
// Self-checking testbench for the triangle coverage scanner: directed table, then random scans.
module tb_triangle_coverage_scanner_core;

    localparam int NPLAN        = 47;
    localparam int ITEM_TARGET  = 600;
    localparam int HOLD_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 400000;

    // One pixel beat as seen on the output channel
    typedef struct packed {
        logic                                 valid;
        logic [tcs_pkg::PIXEL_COORD_BITS-1:0] x;
        logic [tcs_pkg::PIXEL_COORD_BITS-1:0] y;
        logic                                 cov;
        logic                                 last;
    } t_pixel;

    typedef enum bit {ROW_BEAT, ROW_CFG} t_row_kind;

    // Directed stimulus row: a register write or one tick beat
    typedef struct {
        t_row_kind                    kind;
        logic [tcs_pkg::IDX_W-1:0]    idx;
        logic [tcs_pkg::DATA_W-1:0]   data;
        bit                           start;
        bit                           known;
        t_pixel                       want;
    } t_row;

    localparam t_pixel PIX_IDLE = '0;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_stall;
    logic                                 i_start_scan;
    logic                                 o_out_valid;
    logic                                 i_out_stall;
    logic                                 o_pixel_valid;
    logic [tcs_pkg::PIXEL_COORD_BITS-1:0] o_pixel_x;
    logic [tcs_pkg::PIXEL_COORD_BITS-1:0] o_pixel_y;
    logic                                 o_covered;
    logic                                 o_scan_last;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [tcs_pkg::ADDR_W-1:0]           paddr;
    logic [tcs_pkg::DATA_W-1:0]           pwdata;
    logic [tcs_pkg::DATA_W-1:0]           prdata;
    logic                                 pready;

    triangle_coverage_scanner_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_start_scan (i_start_scan),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_valid(o_pixel_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_covered    (o_covered),
        .o_scan_last  (o_scan_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Shadow of the register file and scan state
    logic signed [tcs_pkg::VERT_W-1:0]    vtx [6];
    logic [tcs_pkg::SIZE_W-1:0]           scr_w;
    logic [tcs_pkg::SIZE_W-1:0]           scr_h;
    logic [tcs_pkg::PIXEL_COORD_BITS-1:0] col_now, row_now, col_stop, row_first, row_stop;
    bit                                   scan_on;
    logic [1:0]                           wind;

    t_pixel pixel_q [$];
    t_pixel seen_want;
    t_row   plan [NPLAN];
    int     bad_pixels;
    int     items_sent;
    int     cycles;
    int     tx_idle_pct;
    int     rx_idle_pct;
    int     hold_left;
    bit     hold_req;
    bit     hold_done;

    always #6 i_clk = ~i_clk;

    // Screen size as the scanner uses it: zero counts as one, oversize is capped
    function automatic logic [tcs_pkg::SIZE_W-1:0] eff_size(
        input logic [tcs_pkg::SIZE_W-1:0] s
    );
        if (s == '0)
            return tcs_pkg::SIZE_W'(1);
        if (s > tcs_pkg::SCREEN_CAP)
            return tcs_pkg::SIZE_W'(tcs_pkg::SCREEN_CAP);
        return s;
    endfunction

    function automatic logic [tcs_pkg::PIXEL_COORD_BITS-1:0] clip_box(
        input int v,
        input logic [tcs_pkg::SIZE_W-1:0] size
    );
        if (v < 0)
            return '0;
        if (v > int'(size) - 1)
            return tcs_pkg::PIXEL_COORD_BITS'(size - 1'b1);
        return tcs_pkg::PIXEL_COORD_BITS'(v);
    endfunction

    function automatic int floor_px(input logic signed [tcs_pkg::VERT_W-1:0] v);
        return int'(v) >>> tcs_pkg::COORD_FRAC_BITS;
    endfunction

    function automatic longint edge_fn(input longint ax, input longint ay, input longint bx,
                                       input longint by, input longint px, input longint py);
        return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    // Half-plane test against the live vertices with the latched winding
    function automatic bit pix_covered(input logic [tcs_pkg::PIXEL_COORD_BITS-1:0] c,
                                       input logic [tcs_pkg::PIXEL_COORD_BITS-1:0] r);
        longint px, py, e0, e1, e2;
        longint x0, y0, x1, y1, x2, y2;
        x0 = longint'(vtx[0]); y0 = longint'(vtx[1]);
        x1 = longint'(vtx[2]); y1 = longint'(vtx[3]);
        x2 = longint'(vtx[4]); y2 = longint'(vtx[5]);
        px = longint'(c) << tcs_pkg::COORD_FRAC_BITS;
        py = longint'(r) << tcs_pkg::COORD_FRAC_BITS;
        e0 = edge_fn(x0, y0, x1, y1, px, py);
        e1 = edge_fn(x1, y1, x2, y2, px, py);
        e2 = edge_fn(x2, y2, x0, y0, px, py);
        if (wind == tcs_pkg::WIND_CCW)
            return e0 >= 0 && e1 >= 0 && e2 >= 0;
        if (wind == tcs_pkg::WIND_CW)
            return e0 <= 0 && e1 <= 0 && e2 <= 0;
        return 1'b0;
    endfunction

    // Latch bounding box and winding of the current triangle
    function automatic void begin_scan();
        int xmin, xmax, ymin, ymax;
        logic [tcs_pkg::SIZE_W-1:0] w, h;
        longint area;
        w = eff_size(scr_w);
        h = eff_size(scr_h);
        xmin = int'(vtx[0]); xmax = int'(vtx[0]);
        ymin = int'(vtx[1]); ymax = int'(vtx[1]);
        for (int i = 1; i < 3; i++) begin
            if (int'(vtx[2*i]) < xmin) xmin = int'(vtx[2*i]);
            if (int'(vtx[2*i]) > xmax) xmax = int'(vtx[2*i]);
            if (int'(vtx[2*i+1]) < ymin) ymin = int'(vtx[2*i+1]);
            if (int'(vtx[2*i+1]) > ymax) ymax = int'(vtx[2*i+1]);
        end
        col_now   = clip_box(floor_px(tcs_pkg::VERT_W'(xmin)) - 1, w);
        col_stop  = clip_box(floor_px(tcs_pkg::VERT_W'(xmax)) + 1, w);
        row_first = clip_box(floor_px(tcs_pkg::VERT_W'(ymin)) - 1, h);
        row_stop  = clip_box(floor_px(tcs_pkg::VERT_W'(ymax)) + 1, h);
        row_now   = row_first;
        area = edge_fn(longint'(vtx[0]), longint'(vtx[1]), longint'(vtx[2]),
                       longint'(vtx[3]), longint'(vtx[4]), longint'(vtx[5]));
        wind = (area > 0) ? tcs_pkg::WIND_CCW :
               ((area < 0) ? tcs_pkg::WIND_CW : tcs_pkg::WIND_NONE);
        scan_on = 1'b1;
    endfunction

    // One tick: emit the current pixel and step column-major through the box
    function automatic t_pixel raster_step(input bit s);
        t_pixel p;
        bit     fin;
        p = '0;
        if (s)
            begin_scan();
        if (!scan_on)
            return p;
        fin    = (col_now == col_stop) && (row_now == row_stop);
        p.valid = 1'b1;
        p.x     = col_now;
        p.y     = row_now;
        p.cov   = pix_covered(col_now, row_now);
        p.last  = fin;
        if (fin) begin
            scan_on = 1'b0;
        end else if (row_now < row_stop) begin
            row_now++;
        end else begin
            row_now = row_first;
            col_now++;
        end
        return p;
    endfunction

    function automatic logic [tcs_pkg::SIZE_W-1:0] rand_size();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return tcs_pkg::SIZE_W'(1);
            2: return '1;
            3: return tcs_pkg::SIZE_W'($urandom_range(1, tcs_pkg::SCREEN_CAP));
            4: return tcs_pkg::SIZE_W'($urandom);
            5: return tcs_pkg::SIZE_W'(800);
            default: return tcs_pkg::SIZE_W'(tcs_pkg::SCREEN_CAP);
        endcase
    endfunction

    // Idle pattern follows progress through the run
    function automatic void set_pace();
        if (items_sent < 200) begin
            tx_idle_pct = 30;
            rx_idle_pct = 87;
        end else if (items_sent < 400) begin
            tx_idle_pct = 87;
            rx_idle_pct = 30;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endfunction

    // APB write: setup, then access; shadow updated at the write edge
    task automatic reg_write(input logic [tcs_pkg::IDX_W-1:0] idx,
                             input logic [tcs_pkg::DATA_W-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tcs_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx < tcs_pkg::REG_SCREEN_W)
            vtx[idx] = word[tcs_pkg::VERT_W-1:0];
        else if (idx == tcs_pkg::REG_SCREEN_W)
            scr_w = word[tcs_pkg::SIZE_W-1:0];
        else
            scr_h = word[tcs_pkg::SIZE_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one tick beat and record its expected pixel once taken
    task automatic send_beat(input bit s, input bit known, input t_pixel typed);
        t_pixel p;
        set_pace();
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_start_scan <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        p = raster_step(s);
        pixel_q.insert(pixel_q.size(), known ? typed : p);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every pixel in flight has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // One random triangle: set up while idle, then scan it with some noise
    task automatic run_phase();
        int vx [3];
        int vy [3];
        int bx, by, dx, dy, n, mode;
        bit fresh, big;
        drain();
        big   = !hold_done && items_sent >= 420;
        fresh = big || ($urandom_range(0, 5) != 0);
        if (big) begin
            // full screen so the long hold-off meets a scan that keeps going
            reg_write(tcs_pkg::REG_SCREEN_W, tcs_pkg::DATA_W'(tcs_pkg::SCREEN_CAP));
            reg_write(tcs_pkg::REG_SCREEN_H, tcs_pkg::DATA_W'(tcs_pkg::SCREEN_CAP));
        end else if ($urandom_range(0, 5) == 0) begin
            reg_write(tcs_pkg::REG_SCREEN_W, {21'($urandom), rand_size()});
            reg_write(tcs_pkg::REG_SCREEN_H, {21'($urandom), rand_size()});
        end
        mode = big ? 3 : $urandom_range(0, 9);
        bx = $urandom_range(0, 1100 * 16) - 48 * 16;
        by = $urandom_range(0, 1100 * 16) - 48 * 16;
        dx = $urandom_range(0, 64) - 32;
        dy = $urandom_range(0, 64) - 32;
        for (int i = 0; i < 3; i++) begin
            case (mode)
                0: begin
                    vx[i] = $urandom_range(0, 65535) - 32768;
                    vy[i] = $urandom_range(0, 65535) - 32768;
                end
                1: begin
                    // collinear points, zero area
                    vx[i] = bx + i * dx;
                    vy[i] = by + i * dy;
                end
                3: begin
                    vx[i] = 256 + i * 2048;
                    vy[i] = 256 + (2 - i) * 2048;
                end
                default: begin
                    vx[i] = bx + $urandom_range(0, 64) - 32;
                    vy[i] = by + $urandom_range(0, 64) - 32;
                end
            endcase
        end
        // a write without a fresh start lands in the middle of an open scan
        if (fresh || $urandom_range(0, 1) == 1) begin
            for (int i = 0; i < 3; i++) begin
                reg_write(tcs_pkg::IDX_W'(tcs_pkg::REG_VERT0_X + 2 * i),
                          {16'($urandom), 16'(vx[i])});
                reg_write(tcs_pkg::IDX_W'(tcs_pkg::REG_VERT0_Y + 2 * i),
                          {16'($urandom), 16'(vy[i])});
            end
        end
        if (big) begin
            hold_req  = 1'b1;
            hold_done = 1'b1;
        end
        n = 0;
        if (fresh) begin
            send_beat(1'b1, 1'b0, PIX_IDLE);
            n = 1;
        end
        while (scan_on && n < (big ? 40 : 48)) begin
            send_beat($urandom_range(0, 49) == 0, 1'b0, PIX_IDLE);
            n++;
        end
        repeat ($urandom_range(0, 2)) send_beat(1'b0, 1'b0, PIX_IDLE);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Output checker against the oldest expected pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixel_q.size() == 0) begin
                bad_pixels++;
                if (bad_pixels <= 10)
                    $display("unexpected beat: v%0b x%0d y%0d cov%0b last%0b",
                             o_pixel_valid, o_pixel_x, o_pixel_y, o_covered, o_scan_last);
            end else begin
                seen_want = pixel_q.pop_front();
                if (o_pixel_valid !== seen_want.valid || o_pixel_x !== seen_want.x ||
                    o_pixel_y !== seen_want.y || o_covered !== seen_want.cov ||
                    o_scan_last !== seen_want.last) begin
                    bad_pixels++;
                    if (bad_pixels <= 10)
                        $display({"pixel mismatch: want v%0b x%0d y%0d cov%0b last%0b, ",
                                  "got v%0b x%0d y%0d cov%0b last%0b"},
                                 seen_want.valid, seen_want.x, seen_want.y, seen_want.cov,
                                 seen_want.last, o_pixel_valid, o_pixel_x, o_pixel_y,
                                 o_covered, o_scan_last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_start_scan = 1'b0;
        i_out_stall  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cycles       = 0;
        bad_pixels   = 0;
        items_sent   = 0;
        hold_left    = 0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        tx_idle_pct  = 30;
        rx_idle_pct  = 87;
        for (int i = 0; i < 6; i++)
            vtx[i] = '0;
        scr_w     = tcs_pkg::SCREEN_W_RST;
        scr_h     = tcs_pkg::SCREEN_H_RST;
        col_now   = '0;
        row_now   = '0;
        col_stop  = '0;
        row_first = '0;
        row_stop  = '0;
        scan_on   = 1'b0;
        wind      = tcs_pkg::WIND_NONE;

        plan = '{
            // after reset: idle tick, then the all-zero triangle (degenerate, 2x2 box)
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b1, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b1, 1'b1,
              '{1'b1, 10'd0, 10'd0, 1'b0, 1'b0}},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b1,
              '{1'b1, 10'd0, 10'd1, 1'b0, 1'b0}},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b1,
              '{1'b1, 10'd1, 10'd0, 1'b0, 1'b0}},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b1,
              '{1'b1, 10'd1, 10'd1, 1'b0, 1'b1}},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b1, PIX_IDLE},
            // 1x1 screen, counter-clockwise triangle touching the only pixel
            '{ROW_CFG,  tcs_pkg::REG_SCREEN_W, 32'd1, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_SCREEN_H, 32'd1, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT1_X, 32'd16, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT2_Y, 32'd16, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b1, 1'b1,
              '{1'b1, 10'd0, 10'd0, 1'b1, 1'b1}},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b1, PIX_IDLE},
            // same triangle wound clockwise
            '{ROW_CFG,  tcs_pkg::REG_VERT1_X, 32'd0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT1_Y, 32'd16, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT2_X, 32'd16, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT2_Y, 32'd0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b1, 1'b0, PIX_IDLE},
            // out-of-range screen sizes and extreme vertices
            '{ROW_CFG,  tcs_pkg::REG_SCREEN_W, 32'd0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_SCREEN_H, 32'h7FF, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT0_X, 32'h8000, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT0_Y, 32'h8000, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT1_X, 32'h7FFF, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT1_Y, 32'h8000, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT2_X, 32'h8000, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT2_Y, 32'h7FFF, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b1, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b0, PIX_IDLE},
            // vertex moved while the scan is open
            '{ROW_CFG,  tcs_pkg::REG_VERT2_X, 32'h10, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b0, PIX_IDLE},
            // full-size screen, restart mid-scan
            '{ROW_CFG,  tcs_pkg::REG_SCREEN_W, 32'h400, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_SCREEN_H, 32'h400, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b1, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b1, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b0, PIX_IDLE},
            // point triangle in the far corner: box clamped to the last pixel
            '{ROW_CFG,  tcs_pkg::REG_VERT0_X, 32'h3FF0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT0_Y, 32'h3FF0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT1_X, 32'h3FF0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT1_Y, 32'h3FF0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT2_X, 32'h3FF0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_CFG,  tcs_pkg::REG_VERT2_Y, 32'h3FF0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b1, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b0, PIX_IDLE},
            '{ROW_BEAT, tcs_pkg::REG_VERT0_X, 32'd0, 1'b0, 1'b1, PIX_IDLE}
        };

        // reset
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int k = 0; k < NPLAN; k++) begin
            if (plan[k].kind == ROW_CFG) begin
                drain();
                reg_write(plan[k].idx, plan[k].data);
            end else begin
                send_beat(plan[k].start, plan[k].known, plan[k].want);
            end
        end

        // random triangles
        while (items_sent < ITEM_TARGET)
            run_phase();

        drain();
        repeat (10) @(negedge i_clk);
        if (bad_pixels == 0 && pixel_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
